// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISFB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/isfb_pkg.sv =====
// ----------------------------------------------------------------------------
// isfb_pkg
// Shared types, constants and the gyro debias function of the frame builder.
// ----------------------------------------------------------------------------
package isfb_pkg;

    localparam int unsigned SENSOR_SLOTS   = 3;
    localparam int unsigned BIAS_FRAC_BITS = 4;
    localparam int unsigned BIAS_FIELD_W   = 20;
    localparam int unsigned BIAS_REGS      = 3;
    localparam int unsigned CFG_DATA_W     = 60;
    localparam int unsigned CFG_IDX_W      = 2;

    localparam logic [7:0] SYNC0      = 8'hAA;
    localparam logic [7:0] SYNC1      = 8'h55;
    localparam logic [7:0] FRAME_TYPE = 8'h01;

    localparam int unsigned HDR_FIXED_BYTES = 4 + 4;
    localparam int unsigned SENSOR_BYTES    = 6 * 2;
    localparam int unsigned HDR_BYTES       = 12;
    localparam int unsigned BODY_BYTES      = HDR_BYTES + SENSOR_BYTES;
    localparam int unsigned CKSUM_IDX       = BODY_BYTES;
    localparam int unsigned BYTE_IDX_W      = $clog2(CKSUM_IDX + 1);

    localparam int unsigned QUEUE_DEPTH = 2;

    // Debias datapath width: room for raw << frac, the bias, and a sign bit.
    localparam int unsigned DIFF_W =
        ((16 + BIAS_FRAC_BITS > BIAS_FIELD_W) ? 16 + BIAS_FRAC_BITS : BIAS_FIELD_W) + 1;
    localparam int unsigned ROUND_HALF = (BIAS_FRAC_BITS > 0) ? (1 << (BIAS_FRAC_BITS - 1)) : 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SENSORS = 2'd0,
        CFG_GYRO_BIAS0  = 2'd1,
        CFG_GYRO_BIAS1  = 2'd2,
        CFG_GYRO_BIAS2  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]        elapsed_us;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic               read_ok;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       item_done;
        logic       frame_end;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]                              num_sensors;
        logic [BIAS_REGS-1:0][CFG_DATA_W-1:0]    gyro_bias;
    } cfg_t;

    // One classified reading, ready for serialization.
    typedef struct packed {
        logic              hdr_open;
        logic              frame_close;
        logic [7:0]        size_byte;
        logic [31:0]       elapsed_us;
        logic [31:0]       sample_count;
        logic [5:0][15:0]  words;   // accel x,y,z then gyro x,y,z
    } job_t;

    // raw - bias (Q.frac), rounded half away from zero, saturated to int16.
    function automatic logic [15:0] debias(input logic signed [15:0] raw,
                                           input logic signed [BIAS_FIELD_W-1:0] bias);
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        logic [DIFF_W-1:0]        q_mag;
        logic                     neg;
        logic [15:0]              res;
        diff  = (DIFF_W'(raw) <<< BIAS_FRAC_BITS) - DIFF_W'(bias);
        neg   = diff[DIFF_W-1];
        mag   = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
        q_mag = (mag + DIFF_W'(ROUND_HALF)) >> BIAS_FRAC_BITS;
        if (!neg) begin
            res = (q_mag > DIFF_W'(32767)) ? 16'h7FFF : q_mag[15:0];
        end else begin
            res = (q_mag > DIFF_W'(32768)) ? 16'h8000 : 16'(-q_mag);
        end
        return res;
    endfunction

endpackage

// ===== hdl/isfb_front.sv =====
// ----------------------------------------------------------------------------
// isfb_front
// Accepts sensor readings, tracks sample position and counter, applies gyro
// debias and pushes one job per reading into the queue.
// ----------------------------------------------------------------------------
module isfb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  isfb_pkg::in_beat_t s_data,
    input  isfb_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              q_push,
    output isfb_pkg::job_t    q_job
);

    logic [1:0]  pos_reg, pos_next;
    logic [31:0] counter_reg, counter_next;
    logic [1:0]  count_eff;
    logic [1:0]  bias_sel;
    logic [isfb_pkg::CFG_DATA_W-1:0] bias_word;
    logic        hdr_open;
    logic        frame_close;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        // zero acts as one, above the slot count clamps to it
        if (cfg.num_sensors == 2'd0) begin
            count_eff = 2'd1;
        end else if (32'(cfg.num_sensors) > isfb_pkg::SENSOR_SLOTS) begin
            count_eff = 2'(isfb_pkg::SENSOR_SLOTS);
        end else begin
            count_eff = cfg.num_sensors;
        end
        hdr_open    = (pos_reg == 2'd0);
        frame_close = ({1'b0, pos_reg} + 3'd1) >= {1'b0, count_eff};
        bias_sel    = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
        bias_word   = cfg.gyro_bias[bias_sel];
    end

    always_comb begin
        q_job.hdr_open     = hdr_open;
        q_job.frame_close  = frame_close;
        q_job.size_byte    = 8'(isfb_pkg::HDR_FIXED_BYTES) + 8'(count_eff) * 8'(isfb_pkg::SENSOR_BYTES);
        q_job.elapsed_us   = s_data.elapsed_us;
        q_job.sample_count = counter_reg;
        if (s_data.read_ok) begin
            q_job.words[0] = s_data.accel_x;
            q_job.words[1] = s_data.accel_y;
            q_job.words[2] = s_data.accel_z;
            q_job.words[3] = isfb_pkg::debias(s_data.rate_x, bias_word[19:0]);
            q_job.words[4] = isfb_pkg::debias(s_data.rate_y, bias_word[39:20]);
            q_job.words[5] = isfb_pkg::debias(s_data.rate_z, bias_word[59:40]);
        end else begin
            q_job.words = '0;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        counter_next = counter_reg;
        if (q_push) begin
            pos_next = frame_close ? 2'd0 : pos_reg + 2'd1;
            if (hdr_open) begin
                counter_next = counter_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 2'd0;
            counter_reg <= 32'd0;
        end else begin
            pos_reg     <= pos_next;
            counter_reg <= counter_next;
        end
    end

endmodule

// ===== hdl/isfb_queue.sv =====
// ----------------------------------------------------------------------------
// isfb_queue
// Short job queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module isfb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  isfb_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output isfb_pkg::job_t head_job
);

    localparam int unsigned PTR_W = (isfb_pkg::QUEUE_DEPTH > 1) ? $clog2(isfb_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(isfb_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(isfb_pkg::QUEUE_DEPTH - 1);

    isfb_pkg::job_t entries_reg [isfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(isfb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/isfb_back.sv =====
// ----------------------------------------------------------------------------
// isfb_back
// Byte serializer: walks each queued job byte by byte into the output
// register, keeps the running XOR and appends the checksum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isfb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  isfb_pkg::job_t     head_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output isfb_pkg::out_beat_t m_data
);

    localparam int unsigned IW = isfb_pkg::BYTE_IDX_W;

    logic [IW-1:0] idx_reg, idx_next;
    logic          started_reg, started_next;
    logic [7:0]    xor_reg, xor_next;
    logic          m_valid_reg, m_valid_next;
    isfb_pkg::out_beat_t m_data_reg, m_data_next;

    logic [IW-1:0] idx_cur;
    logic [IW-1:0] idx_last;
    logic          issue;
    logic          last;
    logic          is_cksum;
    logic [7:0]    cur_byte;
    logic [isfb_pkg::BODY_BYTES-1:0][7:0] body;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        // little-endian layout: sync, type, size, elapsed, counter, six words
        body = {head_job.words, head_job.sample_count, head_job.elapsed_us,
                head_job.size_byte, isfb_pkg::FRAME_TYPE, isfb_pkg::SYNC1, isfb_pkg::SYNC0};
        if (started_reg) begin
            idx_cur = idx_reg;
        end else begin
            idx_cur = head_job.hdr_open ? '0 : IW'(isfb_pkg::HDR_BYTES);
        end
        idx_last = head_job.frame_close ? IW'(isfb_pkg::CKSUM_IDX) : IW'(isfb_pkg::CKSUM_IDX - 1);
        is_cksum = (idx_cur == IW'(isfb_pkg::CKSUM_IDX));
        cur_byte = is_cksum ? xor_reg : body[idx_cur];
        last     = (idx_cur == idx_last);
        issue    = head_valid && (!m_valid_reg || m_ready);
        pop      = issue && last;
    end

    always_comb begin
        idx_next     = idx_reg;
        started_next = started_reg;
        xor_next     = xor_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (issue) begin
            m_valid_next           = 1'b1;
            m_data_next.frame_byte = cur_byte;
            m_data_next.item_done  = last;
            m_data_next.frame_end  = is_cksum;
            xor_next = (idx_cur == '0) ? cur_byte : (xor_reg ^ cur_byte);
            if (last) begin
                started_next = 1'b0;
            end else begin
                started_next = 1'b1;
                idx_next     = idx_cur + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            started_reg <= 1'b0;
            xor_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            started_reg <= started_next;
            xor_reg     <= xor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `ISFB_ASSERT_IMP(a_end_is_done, m_valid_reg && m_data_reg.frame_end, m_data_reg.item_done, "frame end without item done")
    `ISFB_ASSERT_NXT(a_mid_item_started, issue && !last, started_reg, "serializer lost its place mid item")
    `ISFB_ASSERT_IMP(a_pop_at_tail, pop, idx_cur == IW'(isfb_pkg::CKSUM_IDX) || idx_cur == IW'(isfb_pkg::CKSUM_IDX - 1), "job popped before its last byte")

endmodule

// ===== hdl/imu_sample_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// imu_sample_frame_builder_core
// Six-axis sample frame builder: readings in, little-endian frame bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per sensor reading, the configured number of
//     readings per sample.
//   m_* channel: one frame byte per beat; item_done marks the last byte of a
//     reading, frame_end marks the XOR checksum closing the frame.
//   cfg_* channel: register writes (count, three gyro bias words), always
//     ready; write only while no reading is in flight.
// Path: a reading is written into the job queue when accepted; its first
//   byte then goes to the serializer's output register.
// Throughput: a reading costs 12 to 25 output beats (header 12, sensor data
//   12, checksum 1), one byte per cycle from the serializer's output
//   register while m_ready is high. A two-entry job queue lets the front
//   accept the next reading while the serializer is busy.
// Reset: sample counter, sensor position and running XOR clear; count = 1,
//   biases = 0; queue and output register empty.
// Stall: m_ready held low freezes the output register; the serializer waits,
//   the queue fills, then s_ready drops.
// ----------------------------------------------------------------------------
module imu_sample_frame_builder_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // reading input
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  isfb_pkg::in_beat_t                      s_data,
    // frame byte output
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output isfb_pkg::out_beat_t                     m_data,
    // register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [isfb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [isfb_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // configuration registers
    logic [1:0]                         count_reg, count_next;
    logic [isfb_pkg::CFG_DATA_W-1:0]    bias0_reg, bias0_next;
    logic [isfb_pkg::CFG_DATA_W-1:0]    bias1_reg, bias1_next;
    logic [isfb_pkg::CFG_DATA_W-1:0]    bias2_reg, bias2_next;
    isfb_pkg::cfg_t                     cfg;

    // front to queue to serializer
    logic            q_push;
    logic            q_full;
    isfb_pkg::job_t  q_in_job;
    logic            q_pop;
    logic            q_head_valid;
    isfb_pkg::job_t  q_head_job;

    assign cfg_ready = 1'b1;

    always_comb begin
        count_next = count_reg;
        bias0_next = bias0_reg;
        bias1_next = bias1_reg;
        bias2_next = bias2_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (isfb_pkg::cfg_reg_t'(cfg_index))
                isfb_pkg::CFG_NUM_SENSORS: count_next = cfg_data[1:0];
                isfb_pkg::CFG_GYRO_BIAS0:  bias0_next = cfg_data;
                isfb_pkg::CFG_GYRO_BIAS1:  bias1_next = cfg_data;
                isfb_pkg::CFG_GYRO_BIAS2:  bias2_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd1;
            bias0_reg <= '0;
            bias1_reg <= '0;
            bias2_reg <= '0;
        end else begin
            count_reg <= count_next;
            bias0_reg <= bias0_next;
            bias1_reg <= bias1_next;
            bias2_reg <= bias2_next;
        end
    end

    always_comb begin
        cfg.num_sensors  = count_reg;
        cfg.gyro_bias[0] = bias0_reg;
        cfg.gyro_bias[1] = bias1_reg;
        cfg.gyro_bias[2] = bias2_reg;
    end

    // classify the reading, debias gyro, build the job
    isfb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_in_job)
    );

    // decouples intake from serialization
    isfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // one byte per beat, running XOR, checksum
    isfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
